@@ rtl/cst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

	// Width of the center and radius fields.
	localparam int OUT_BITS = 48;
	// Quotient bits computed below the offset clamp.
	localparam int Q_BITS = 62;
	// Offset magnitude clamp, 2^Q_BITS.
	localparam logic [Q_BITS:0] OFF_CLAMP = {1'b1, {Q_BITS{1'b0}}};
	// Half width used to split the offset squares into partial products.
	localparam int SPLIT = 24;
	// Root bits and radicand width once huge offsets are filtered out.
	localparam int R_BITS = OUT_BITS + 1;
	localparam int SQ_W = 2 * R_BITS;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	// Width of the signed triple product.
	function automatic int t_width(int cb);
		return 3 * cb + 6;
	endfunction

	// Width of the doubled triple product magnitude.
	function automatic int d_width(int cb);
		return 3 * cb + 7;
	endfunction

	// Width of the scaled numerator magnitude.
	function automatic int x_width(int cb, int fb);
		return 4 * cb + 8 + fb;
	endfunction

endpackage
`default_nettype wire

@@ rtl/cst_geom.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cst_geom #(
	parameter int CB = 16,
	parameter int FB = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cst_pkg::pipe_ctl_t                        ctl,
	input  logic [12*CB-1:0]                          pts,
	input  logic [31:0]                               thr,
	output logic                                      out_vld,
	output logic                                      out_flat,
	output logic [3*CB-1:0]                           out_a,
	output logic [cst_pkg::d_width(CB)-1:0]           out_d,
	output logic [3*cst_pkg::x_width(CB, FB)-1:0]     out_x,
	output logic [2:0]                                out_sgn
);
	import cst_pkg::*;

	localparam int VW = CB + 1;
	localparam int XW = 2 * VW + 1;
	localparam int LW = XW;
	localparam int TW = t_width(CB);
	localparam int NW = LW + XW + 2;
	localparam int XW2 = x_width(CB, FB);
	localparam int CW = (TW > 32) ? TW : 32;

	logic signed [CB-1:0]       p [4][3];
	logic signed [VW-1:0]       v_s1 [3][3];
	logic signed [CB-1:0]       a_s1 [3], a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3];
	logic signed [2*VW-1:0]     mp [3][3][2];
	logic signed [2*VW-1:0]     sqp [3][3];
	logic signed [2*VW-1:0]     m_s2 [3][3][2];
	logic signed [2*VW-1:0]     sq_s2 [3][3];
	logic signed [VW-1:0]       v0_s2 [3], v0_s3 [3];
	logic signed [XW-1:0]       c_s3 [3][3];
	logic signed [LW-1:0]       l_s3 [3];
	logic signed [VW+XW-1:0]    t_s4 [3];
	logic signed [LW+XW-1:0]    nm_s4 [3][3];
	logic signed [TW-1:0]       vt_s5;
	logic signed [NW-1:0]       n_s5 [3];
	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                       vneg;
	logic [TW-1:0]              vmag;
	logic [NW-1:0]              nmag [3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 3; j++) begin
				p[i][j] = pts[(i*3+j)*CB +: CB];
			end
		end
	end

	// Cross product k pairs edge (k+1)%3 with edge (k+2)%3.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				mp[k][j][0] = v_s1[(k+1)%3][(j+1)%3] * v_s1[(k+2)%3][(j+2)%3];
				mp[k][j][1] = v_s1[(k+1)%3][(j+2)%3] * v_s1[(k+2)%3][(j+1)%3];
				sqp[k][j] = v_s1[k][j] * v_s1[k][j];
			end
		end
	end

	always_comb begin
		vneg = vt_s5[TW-1];
		vmag = vneg ? TW'(-vt_s5) : TW'(vt_s5);
		for (int j = 0; j < 3; j++) begin
			nmag[j] = n_s5[j][NW-1] ? NW'(-n_s5[j]) : NW'(n_s5[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_vld <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			out_vld <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= p[0][i];
				a_s2[i] <= a_s1[i];
				a_s3[i] <= a_s2[i];
				a_s4[i] <= a_s3[i];
				a_s5[i] <= a_s4[i];
				out_a[i*CB +: CB] <= a_s5[i];
				v0_s2[i] <= v_s1[0][i];
				v0_s3[i] <= v0_s2[i];
				for (int j = 0; j < 3; j++) begin
					v_s1[i][j] <= VW'(p[i+1][j]) - VW'(p[0][j]);
					m_s2[i][j][0] <= mp[i][j][0];
					m_s2[i][j][1] <= mp[i][j][1];
					sq_s2[i][j] <= sqp[i][j];
					c_s3[i][j] <= XW'(m_s2[i][j][0]) - XW'(m_s2[i][j][1]);
					nm_s4[i][j] <= l_s3[j] * c_s3[j][i];
				end
				l_s3[i] <= LW'(sq_s2[i][0]) + LW'(sq_s2[i][1]) + LW'(sq_s2[i][2]);
				t_s4[i] <= v0_s3[i] * c_s3[0][i];
				n_s5[i] <= NW'(nm_s4[i][0]) + NW'(nm_s4[i][1]) + NW'(nm_s4[i][2]);
				out_x[i*XW2 +: XW2] <= XW2'(nmag[i]) << FB;
				out_sgn[i] <= n_s5[i][NW-1] ^ vneg;
			end
			vt_s5 <= TW'(t_s4[0]) + TW'(t_s4[1]) + TW'(t_s4[2]);
			out_flat <= CW'(vmag) <= CW'(thr);
			out_d <= {vmag, 1'b0};
		end
	end

endmodule
`default_nettype wire

@@ rtl/cst_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cst_div #(
	parameter int DW = 55,
	parameter int XW2 = 88,
	parameter int SW = 49
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cst_pkg::pipe_ctl_t                 ctl,
	input  logic [SW-1:0]                      in_side,
	input  logic [DW-1:0]                      in_d,
	input  logic [3*XW2-1:0]                   in_x,
	input  logic [2:0]                         in_sgn,
	output logic                               out_vld,
	output logic [SW-1:0]                      out_side,
	output logic [3*64-1:0]                    out_off,
	output logic [3*(cst_pkg::Q_BITS+1)-1:0]   out_mag
);
	import cst_pkg::*;

	localparam int EW = (XW2 > DW + Q_BITS) ? XW2 : DW + Q_BITS;

	logic [DW-1:0]     rem_p [Q_BITS+1][3];
	logic [Q_BITS-1:0] q_p [Q_BITS+1][3];
	logic [Q_BITS-1:0] lo_p [Q_BITS+1][3];
	logic [DW-1:0]     d_p [Q_BITS+1];
	logic [2:0]        sgn_p [Q_BITS+1];
	logic [2:0]        big_p [Q_BITS+1];
	logic [SW-1:0]     side_p [Q_BITS+1];
	logic              vld_p [Q_BITS+1];
	logic [Q_BITS:0]   om [3];

	// A quotient at or above the clamp is caught up front, so the remainder
	// of every lane that is not clamped starts below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p[0] <= 1'b0;
		end else if (ctl.en) begin
			vld_p[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < 3; l++) begin
				big_p[0][l] <= EW'(in_x[l*XW2 +: XW2]) >= (EW'(in_d) << Q_BITS);
				rem_p[0][l] <= DW'(in_x[l*XW2 +: XW2] >> Q_BITS);
				lo_p[0][l] <= Q_BITS'(in_x[l*XW2 +: XW2]);
				q_p[0][l] <= '0;
			end
			d_p[0] <= in_d;
			sgn_p[0] <= in_sgn;
			side_p[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= Q_BITS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_p[k] <= vld_p[k-1];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW:0] t;
			logic        ge;

			assign t = {rem_p[k-1][l], lo_p[k-1][l][Q_BITS-1]};
			assign ge = t >= {1'b0, d_p[k-1]};

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					rem_p[k][l] <= ge ? DW'(t - {1'b0, d_p[k-1]}) : DW'(t);
					q_p[k][l] <= {q_p[k-1][l][Q_BITS-2:0], ge};
					lo_p[k][l] <= lo_p[k-1][l] << 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				d_p[k] <= d_p[k-1];
				sgn_p[k] <= sgn_p[k-1];
				big_p[k] <= big_p[k-1];
				side_p[k] <= side_p[k-1];
			end
		end
	end

	// Round half away from zero on the magnitude, then apply the sign.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (big_p[Q_BITS][l]) begin
				om[l] = OFF_CLAMP;
			end else begin
				om[l] = {1'b0, q_p[Q_BITS][l]}
					+ (Q_BITS+1)'({rem_p[Q_BITS][l], 1'b0} >= {1'b0, d_p[Q_BITS]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (ctl.en) begin
			out_vld <= vld_p[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < 3; l++) begin
				out_off[l*64 +: 64] <= sgn_p[Q_BITS][l] ? -64'(om[l]) : 64'(om[l]);
				out_mag[l*(Q_BITS+1) +: Q_BITS+1] <= om[l];
			end
			out_side <= side_p[Q_BITS];
		end
	end

endmodule
`default_nettype wire

@@ rtl/cst_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cst_sqrt #(
	parameter int SW = 146
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cst_pkg::pipe_ctl_t            ctl,
	input  logic [cst_pkg::SQ_W-1:0]      in_s,
	input  logic [SW-1:0]                 in_side,
	output logic                          out_vld,
	output logic [SW-1:0]                 out_side,
	output logic [cst_pkg::R_BITS:0]      out_root
);
	import cst_pkg::*;

	// The partial remainder stays at or below twice the partial root.
	localparam int RW = R_BITS + 3;

	logic [RW-1:0]     rem_p [1:R_BITS];
	logic [R_BITS-1:0] r_p [1:R_BITS];
	logic [SQ_W-1:0]   s_p [1:R_BITS];
	logic [SW-1:0]     side_p [1:R_BITS];
	logic              vld_p [1:R_BITS];
	logic              rnd;

	for (genvar k = 1; k <= R_BITS; k++) begin : g_stage
		logic [RW-1:0]     src_rem;
		logic [R_BITS-1:0] src_r;
		logic [SQ_W-1:0]   src_s;
		logic [SW-1:0]     src_side;
		logic              src_vld;
		logic [RW-1:0]     t;
		logic [RW-1:0]     trial;
		logic              ge;

		if (k == 1) begin : g_first
			assign src_rem = '0;
			assign src_r = '0;
			assign src_s = in_s;
			assign src_side = in_side;
			assign src_vld = ctl.vld;
		end else begin : g_next
			assign src_rem = rem_p[k-1];
			assign src_r = r_p[k-1];
			assign src_s = s_p[k-1];
			assign src_side = side_p[k-1];
			assign src_vld = vld_p[k-1];
		end

		assign t = {src_rem[RW-3:0], src_s[SQ_W-1 -: 2]};
		assign trial = RW'({src_r, 2'b01});
		assign ge = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_p[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_p[k] <= ge ? t - trial : t;
				r_p[k] <= {src_r[R_BITS-2:0], ge};
				s_p[k] <= src_s << 2;
				side_p[k] <= src_side;
			end
		end
	end

	// The remainder is the radicand minus the root squared.
	assign rnd = rem_p[R_BITS] > RW'(r_p[R_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (ctl.en) begin
			out_vld <= vld_p[R_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			out_root <= (R_BITS+1)'(r_p[R_BITS]) + (R_BITS+1)'(rnd);
			out_side <= side_p[R_BITS];
		end
	end

endmodule
`default_nettype wire

@@ rtl/circumsphere_of_tetrahedron.sv @@
// Throughput: one point set per cycle unless a result would land in a full output
// buffer that is not being read; every stage advances together, and a two-entry
// output buffer keeps the pipeline moving while one result waits.
// Depth is set by the 62 one-bit stages of the three divider lanes and the
// 49 two-bit stages of the square root.
// Reset clears all valid bits, the output buffer and the flatness threshold.
`timescale 1ns / 1ps
`default_nettype none
module circumsphere_of_tetrahedron #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [31:0]                                cfg_wdata,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z, zero fill
	input  logic [((12*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// center_x, center_y, center_z, radius
	output logic [4*cst_pkg::OUT_BITS-1:0]             m_axis_tdata,
	// valid_res
	output logic [0:0]                                 m_axis_tuser
);
	import cst_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = d_width(CB);
	localparam int XW2 = x_width(CB, FRAC_BITS);
	localparam int DSW = 1 + 3 * CB;
	localparam int SSW = 2 + 3 * OUT_BITS;
	localparam int MW = Q_BITS + 1;

	typedef struct packed {
		logic                  valid_res;
		logic [OUT_BITS-1:0]   radius;
		logic [OUT_BITS-1:0]   center_z;
		logic [OUT_BITS-1:0]   center_y;
		logic [OUT_BITS-1:0]   center_x;
	} out_t;

	logic [31:0]            thr_q;
	logic                   en;
	pipe_ctl_t              in_ctl, geo_ctl, div_ctl, sq_ctl;

	logic                   geo_vld, geo_flat;
	logic [3*CB-1:0]        geo_a;
	logic [DW-1:0]          geo_d;
	logic [3*XW2-1:0]       geo_x;
	logic [2:0]             geo_sgn;

	logic                   div_vld;
	logic [DSW-1:0]         div_side;
	logic [3*64-1:0]        div_off;
	logic [3*MW-1:0]        div_mag;

	logic                   vld_c1, vld_c2, vld_c3;
	logic                   huge_c1, huge_c2, huge_c3;
	logic                   flat_c1, flat_c2, flat_c3;
	logic [OUT_BITS-1:0]    cen_c1 [3], cen_c2 [3], cen_c3 [3];
	logic [2*SPLIT-1:0]     ll_c1 [3], lh_c1 [3], hh_c1 [3];
	logic [2*OUT_BITS-1:0]  sq_c2 [3];
	logic [SQ_W-1:0]        s_c3;
	logic [OUT_BITS-1:0]    cen [3];
	logic [2:0]             huge;

	logic                   sq_vld;
	logic [SSW-1:0]         sq_side;
	logic [R_BITS:0]        sq_root;

	out_t                   res;
	out_t                   mem_q [2];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// The whole pipeline moves unless a result would land in a full buffer.
	assign en = !sq_vld || (cnt_q != 2'd2) || m_axis_tready;
	assign s_axis_tready = en;

	assign in_ctl = '{en: en, vld: s_axis_tvalid};
	assign geo_ctl = '{en: en, vld: geo_vld};
	assign div_ctl = '{en: en, vld: div_vld};
	assign sq_ctl = '{en: en, vld: vld_c3};

	cst_geom #(.CB(CB), .FB(FRAC_BITS)) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (in_ctl),
		.pts      (s_axis_tdata[12*CB-1:0]),
		.thr      (thr_q),
		.out_vld  (geo_vld),
		.out_flat (geo_flat),
		.out_a    (geo_a),
		.out_d    (geo_d),
		.out_x    (geo_x),
		.out_sgn  (geo_sgn)
	);

	cst_div #(.DW(DW), .XW2(XW2), .SW(DSW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (geo_ctl),
		.in_side  ({geo_flat, geo_a}),
		.in_d     (geo_d),
		.in_x     (geo_x),
		.in_sgn   (geo_sgn),
		.out_vld  (div_vld),
		.out_side (div_side),
		.out_off  (div_off),
		.out_mag  (div_mag)
	);

	// Center: first point scaled up plus the offset, clipped to 48 bits.
	always_comb begin
		logic signed [CB-1:0] aj;
		logic signed [63:0]   oj;
		logic signed [65:0]   cs;
		for (int j = 0; j < 3; j++) begin
			aj = div_side[j*CB +: CB];
			oj = div_off[j*64 +: 64];
			cs = (66'(aj) <<< FRAC_BITS) + 66'(oj);
			if (cs[65:OUT_BITS-1] == '0 || cs[65:OUT_BITS-1] == '1) begin
				cen[j] = cs[OUT_BITS-1:0];
			end else begin
				cen[j] = {cs[65], {(OUT_BITS-1){!cs[65]}}};
			end
			// An offset of 2^48 or more already saturates the radius.
			huge[j] = |div_mag[j*MW+OUT_BITS +: MW-OUT_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
		end else if (en) begin
			vld_c1 <= div_vld;
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				cen_c1[j] <= cen[j];
				cen_c2[j] <= cen_c1[j];
				cen_c3[j] <= cen_c2[j];
				ll_c1[j] <= div_mag[j*MW +: SPLIT] * div_mag[j*MW +: SPLIT];
				lh_c1[j] <= div_mag[j*MW +: SPLIT] * div_mag[j*MW+SPLIT +: SPLIT];
				hh_c1[j] <= div_mag[j*MW+SPLIT +: SPLIT] * div_mag[j*MW+SPLIT +: SPLIT];
				sq_c2[j] <= ((2*OUT_BITS)'(hh_c1[j]) << (2*SPLIT))
					+ ((2*OUT_BITS)'(lh_c1[j]) << (SPLIT+1))
					+ (2*OUT_BITS)'(ll_c1[j]);
			end
			huge_c1 <= |huge;
			huge_c2 <= huge_c1;
			huge_c3 <= huge_c2;
			flat_c1 <= div_side[DSW-1];
			flat_c2 <= flat_c1;
			flat_c3 <= flat_c2;
			s_c3 <= SQ_W'(sq_c2[0]) + SQ_W'(sq_c2[1]) + SQ_W'(sq_c2[2]);
		end
	end

	cst_sqrt #(.SW(SSW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sq_ctl),
		.in_s     (s_c3),
		.in_side  ({huge_c3, flat_c3, cen_c3[2], cen_c3[1], cen_c3[0]}),
		.out_vld  (sq_vld),
		.out_side (sq_side),
		.out_root (sq_root)
	);

	always_comb begin
		res = '0;
		if (!sq_side[SSW-2]) begin
			res.valid_res = 1'b1;
			res.center_x = sq_side[0 +: OUT_BITS];
			res.center_y = sq_side[OUT_BITS +: OUT_BITS];
			res.center_z = sq_side[2*OUT_BITS +: OUT_BITS];
			if (sq_side[SSW-1] || (|sq_root[R_BITS:OUT_BITS])) begin
				res.radius = '1;
			end else begin
				res.radius = sq_root[OUT_BITS-1:0];
			end
		end
	end

	assign push = sq_vld && en;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata = {mem_q[rd_ptr_q].radius, mem_q[rd_ptr_q].center_z,
		mem_q[rd_ptr_q].center_y, mem_q[rd_ptr_q].center_x};
	assign m_axis_tuser = mem_q[rd_ptr_q].valid_res;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("coplanar result carries nonzero fields");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("buffer count did not drop on a take");

endmodule
`default_nettype wire
